FILE: hw/rtl/pedal_plausibility_monitor_assert.svh
// Assertion macros shared by the pedal plausibility monitor RTL.
`ifndef PEDAL_PLAUSIBILITY_MONITOR_ASSERT_SVH
`define PEDAL_PLAUSIBILITY_MONITOR_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define PPM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pedal monitor: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define PPM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pedal monitor: next-cycle check failed");

`endif

FILE: hw/rtl/ppm_pkg.sv
// Shared types and constants of the pedal plausibility monitor.
package ppm_pkg;

    localparam int ADC_W   = 16;
    localparam int ANGLE_W = 12;
    localparam int DRIVE_W = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 8;

    typedef logic [ADC_W-1:0]   adc_t;
    typedef logic [ANGLE_W-1:0] angle_t;
    typedef logic [CFG_W-1:0]   cfg_t;

    // Saturation limit of a mapped angle, 1/16 degree
    localparam angle_t ANGLE_MAX = angle_t'(4095);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PEDAL_A_ZERO       = 8'd0,
        REG_PEDAL_A_GAIN       = 8'd1,
        REG_PEDAL_B_ZERO       = 8'd2,
        REG_PEDAL_B_GAIN       = 8'd3,
        REG_DISAGREE_WINDOW_MS = 8'd4,
        REG_BRAKE_LOW_LIMIT    = 8'd5,
        REG_BRAKE_HIGH_LIMIT   = 8'd6,
        REG_BRAKE_FAULT_MS     = 8'd7
    } reg_idx_t;

    // Reset values of the configuration registers
    localparam cfg_t RST_PEDAL_A_ZERO       = cfg_t'(8440);
    localparam cfg_t RST_PEDAL_A_GAIN       = cfg_t'(2441);
    localparam cfg_t RST_PEDAL_B_ZERO       = cfg_t'(7944);
    localparam cfg_t RST_PEDAL_B_GAIN       = cfg_t'(2534);
    localparam cfg_t RST_DISAGREE_WINDOW_MS = cfg_t'(100);
    localparam cfg_t RST_BRAKE_LOW_LIMIT    = cfg_t'(4500);
    localparam cfg_t RST_BRAKE_HIGH_LIMIT   = cfg_t'(48000);
    localparam cfg_t RST_BRAKE_FAULT_MS     = cfg_t'(100);

endpackage

FILE: hw/rtl/ppm_angle_map.sv
// Linear ADC-to-angle mapping with offset, Q16 gain and saturation.
module ppm_angle_map (
    input  ppm_pkg::adc_t   raw,
    input  ppm_pkg::cfg_t   zero,
    input  ppm_pkg::cfg_t   gain,
    output ppm_pkg::angle_t angle
);

    logic [ppm_pkg::ADC_W-1:0]   delta;
    logic [2*ppm_pkg::ADC_W-1:0] prod;
    logic [ppm_pkg::ADC_W-1:0]   scaled;

    // Offset removal, one 16x16 multiply, Q16 truncation
    assign delta  = raw - zero;
    assign prod   = delta * gain;
    assign scaled = prod[2*ppm_pkg::ADC_W-1:ppm_pkg::ADC_W];

    // Readings at or below the zero point give 0; large ones clip
    always_comb begin
        if (raw <= zero) begin
            angle = '0;
        end else if (scaled > ppm_pkg::ADC_W'(ppm_pkg::ANGLE_MAX)) begin
            angle = ppm_pkg::ANGLE_MAX;
        end else begin
            angle = scaled[ppm_pkg::ANGLE_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/pedal_plausibility_monitor.sv
// Pipeline: the input, angle and result registers lie between request acceptance and result valid.
// Throughput: one request per cycle; the angle multipliers and the time compare each
// own a stage, so a new sample enters every cycle while the output is taken.
// Reset: synchronous, active low; clears the pipeline valids, the timing state and
// the fault latch, and loads the configuration registers with their defaults.
`include "pedal_plausibility_monitor_assert.svh"

module pedal_plausibility_monitor #(
    parameter int TIME_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ppm_pkg::IDX_W-1:0] cfg_index,
    input  ppm_pkg::cfg_t            cfg_data,
    // sample requests
    input  logic                     s_valid,
    output logic                     s_ready,
    input  ppm_pkg::adc_t            s_pedal_a_raw,
    input  ppm_pkg::adc_t            s_pedal_b_raw,
    input  ppm_pkg::adc_t            s_brake_raw,
    input  logic [31:0]              s_now_ms,
    // results
    output logic                     m_valid,
    input  logic                     m_ready,
    output ppm_pkg::angle_t          m_pedal_a_angle,
    output ppm_pkg::angle_t          m_pedal_b_angle,
    output logic [ppm_pkg::DRIVE_W-1:0] m_drive_value,
    output logic                     m_torque_fault,
    output logic                     m_disagreeing,
    output logic                     m_brake_fault
);

    typedef logic [TIME_BITS-1:0] stamp_t;

    // ---------------- configuration registers ----------------
    ppm_pkg::cfg_t a_zero_reg, a_gain_reg, b_zero_reg, b_gain_reg;
    ppm_pkg::cfg_t window_reg, brk_low_reg, brk_high_reg, brk_ms_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_zero_reg   <= ppm_pkg::RST_PEDAL_A_ZERO;
            a_gain_reg   <= ppm_pkg::RST_PEDAL_A_GAIN;
            b_zero_reg   <= ppm_pkg::RST_PEDAL_B_ZERO;
            b_gain_reg   <= ppm_pkg::RST_PEDAL_B_GAIN;
            window_reg   <= ppm_pkg::RST_DISAGREE_WINDOW_MS;
            brk_low_reg  <= ppm_pkg::RST_BRAKE_LOW_LIMIT;
            brk_high_reg <= ppm_pkg::RST_BRAKE_HIGH_LIMIT;
            brk_ms_reg   <= ppm_pkg::RST_BRAKE_FAULT_MS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ppm_pkg::REG_PEDAL_A_ZERO:       a_zero_reg   <= cfg_data;
                ppm_pkg::REG_PEDAL_A_GAIN:       a_gain_reg   <= cfg_data;
                ppm_pkg::REG_PEDAL_B_ZERO:       b_zero_reg   <= cfg_data;
                ppm_pkg::REG_PEDAL_B_GAIN:       b_gain_reg   <= cfg_data;
                ppm_pkg::REG_DISAGREE_WINDOW_MS: window_reg   <= cfg_data;
                ppm_pkg::REG_BRAKE_LOW_LIMIT:    brk_low_reg  <= cfg_data;
                ppm_pkg::REG_BRAKE_HIGH_LIMIT:   brk_high_reg <= cfg_data;
                ppm_pkg::REG_BRAKE_FAULT_MS:     brk_ms_reg   <= cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic s0_valid_reg, s1_valid_reg, m_valid_reg;
    logic out_ready, s1_ready, s0_adv, s1_adv, s_fire;

    assign out_ready = !m_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s0_adv    = s0_valid_reg && s1_ready;
    assign s_ready   = !s0_valid_reg || s1_ready;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s0_valid_reg <= s_valid;
            end
            if (s1_ready) begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ---------------- stage 0: input register ----------------
    ppm_pkg::adc_t s0_a_raw_reg, s0_b_raw_reg, s0_brake_reg;
    stamp_t        s0_now_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s0_a_raw_reg <= s_pedal_a_raw;
            s0_b_raw_reg <= s_pedal_b_raw;
            s0_brake_reg <= s_brake_raw;
            s0_now_reg   <= TIME_BITS'(s_now_ms);
        end
    end

    // ---------------- stage 1: angle mapping, brake band ----------------
    ppm_pkg::angle_t ang_a, ang_b;
    logic            brake_oob;

    ppm_angle_map u_map_a (
        .raw   (s0_a_raw_reg),
        .zero  (a_zero_reg),
        .gain  (a_gain_reg),
        .angle (ang_a)
    );

    ppm_angle_map u_map_b (
        .raw   (s0_b_raw_reg),
        .zero  (b_zero_reg),
        .gain  (b_gain_reg),
        .angle (ang_b)
    );

    assign brake_oob = (s0_brake_reg < brk_low_reg) || (s0_brake_reg > brk_high_reg);

    ppm_pkg::angle_t s1_ang_a_reg, s1_ang_b_reg;
    logic            s1_oob_reg;
    stamp_t          s1_now_reg;

    always_ff @(posedge aclk) begin
        if (s0_adv) begin
            s1_ang_a_reg <= ang_a;
            s1_ang_b_reg <= ang_b;
            s1_oob_reg   <= brake_oob;
            s1_now_reg   <= s0_now_reg;
        end
    end

    // ---------------- stage 2: plausibility and timing state ----------------
    logic            disagree_active_reg, disagree_active_next;
    stamp_t          disagree_start_reg, disagree_start_next;
    stamp_t          brake_last_ok_reg, brake_last_ok_next;
    logic            brake_fault_latched_reg, brake_fault_latched_next;

    ppm_pkg::angle_t hi_ang, diff_ang;
    logic [ppm_pkg::ADC_W-1:0] diff_x10;
    logic            disagree, tfault;
    stamp_t          start_eff, dis_elapsed, brk_elapsed;

    // 10 * diff > max is the exact form of "more than 10 percent apart"
    always_comb begin
        if (s1_ang_a_reg > s1_ang_b_reg) begin
            hi_ang   = s1_ang_a_reg;
            diff_ang = s1_ang_a_reg - s1_ang_b_reg;
        end else begin
            hi_ang   = s1_ang_b_reg;
            diff_ang = s1_ang_b_reg - s1_ang_a_reg;
        end
        diff_x10 = {1'b0, diff_ang, 3'b000} + {3'b000, diff_ang, 1'b0};
        disagree = diff_x10 > ppm_pkg::ADC_W'(hi_ang);
    end

    // Persistence timer: a fresh disagreement starts at this sample
    always_comb begin
        start_eff   = disagree_active_reg ? disagree_start_reg : s1_now_reg;
        dis_elapsed = s1_now_reg - start_eff;
        tfault      = disagree && (dis_elapsed > TIME_BITS'(window_reg));

        disagree_active_next = disagree;
        disagree_start_next  = start_eff;
    end

    // Brake band monitor with sticky fault
    always_comb begin
        brk_elapsed              = s1_now_reg - brake_last_ok_reg;
        brake_last_ok_next       = brake_last_ok_reg;
        brake_fault_latched_next = brake_fault_latched_reg;
        if (!s1_oob_reg) begin
            brake_last_ok_next = s1_now_reg;
        end else if (brk_elapsed >= TIME_BITS'(brk_ms_reg)) begin
            brake_last_ok_next       = s1_now_reg;
            brake_fault_latched_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disagree_active_reg     <= 1'b0;
            disagree_start_reg      <= '0;
            brake_last_ok_reg       <= '0;
            brake_fault_latched_reg <= 1'b0;
        end else if (s1_adv) begin
            disagree_active_reg     <= disagree_active_next;
            disagree_start_reg      <= disagree_start_next;
            brake_last_ok_reg       <= brake_last_ok_next;
            brake_fault_latched_reg <= brake_fault_latched_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_pedal_a_angle <= s1_ang_a_reg;
            m_pedal_b_angle <= s1_ang_b_reg;
            m_drive_value   <= tfault ? '0 : hi_ang[ppm_pkg::ANGLE_W-1:4];
            m_torque_fault  <= tfault;
            m_disagreeing   <= disagree;
            m_brake_fault   <= brake_fault_latched_next;
        end
    end

    assign m_valid = m_valid_reg;

    // ---------------- assertions ----------------
    `PPM_ASSERT_IMPL(a_fault_zero_drive, aclk, aresetn,
        m_valid && m_torque_fault, m_drive_value == '0)
    `PPM_ASSERT_IMPL(a_fault_needs_disagree, aclk, aresetn,
        m_valid && m_torque_fault, m_disagreeing)
    `PPM_ASSERT_NEXT(a_brake_fault_sticky, aclk, aresetn,
        brake_fault_latched_reg, brake_fault_latched_reg)
    `PPM_ASSERT_NEXT(a_active_holds_on_stall, aclk, aresetn,
        disagree_active_reg && !s1_adv, disagree_active_reg)
    `PPM_ASSERT_IMPL(a_no_advance_into_full, aclk, aresetn,
        m_valid_reg && !m_ready, !s1_adv)

endmodule

FILE: sim/pedal_plausibility_monitor_tb.sv
// Self-checking testbench of the pedal plausibility monitor: directed and random sample requests.
module pedal_plausibility_monitor_tb;

    // Writes to these indexes fall past the register list and must be dropped
    localparam logic [ppm_pkg::IDX_W-1:0] IDX_PAST_END =
        ppm_pkg::IDX_W'(ppm_pkg::REG_BRAKE_FAULT_MS) + 1'b1;
    localparam logic [ppm_pkg::IDX_W-1:0] IDX_TOP = '1;
    localparam int               SETTLE_CYCLES = 8;
    localparam int               DRAIN_LIMIT   = 4000;
    localparam int               PHASE_ITEMS   = 220;

    typedef struct packed {
        ppm_pkg::angle_t              a_angle;
        ppm_pkg::angle_t              b_angle;
        logic [ppm_pkg::DRIVE_W-1:0]  drive;
        logic                         torque_fault;
        logic                         disagreeing;
        logic                         brake_fault;
    } pedal_result_t;

    // Tracks register values and timing state, predicts one result per sample
    class monitor_scoreboard;
        ppm_pkg::cfg_t   regs [8];
        bit              disagree_on;
        logic [31:0]     disagree_t0;
        logic [31:0]     brake_ok_ms;
        bit              brake_latch;
        pedal_result_t   expected_results [$];
        int unsigned     errors;

        function new();
            regs[ppm_pkg::REG_PEDAL_A_ZERO]       = ppm_pkg::RST_PEDAL_A_ZERO;
            regs[ppm_pkg::REG_PEDAL_A_GAIN]       = ppm_pkg::RST_PEDAL_A_GAIN;
            regs[ppm_pkg::REG_PEDAL_B_ZERO]       = ppm_pkg::RST_PEDAL_B_ZERO;
            regs[ppm_pkg::REG_PEDAL_B_GAIN]       = ppm_pkg::RST_PEDAL_B_GAIN;
            regs[ppm_pkg::REG_DISAGREE_WINDOW_MS] = ppm_pkg::RST_DISAGREE_WINDOW_MS;
            regs[ppm_pkg::REG_BRAKE_LOW_LIMIT]    = ppm_pkg::RST_BRAKE_LOW_LIMIT;
            regs[ppm_pkg::REG_BRAKE_HIGH_LIMIT]   = ppm_pkg::RST_BRAKE_HIGH_LIMIT;
            regs[ppm_pkg::REG_BRAKE_FAULT_MS]     = ppm_pkg::RST_BRAKE_FAULT_MS;
            disagree_on = 1'b0;
            disagree_t0 = '0;
            brake_ok_ms = '0;
            brake_latch = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [ppm_pkg::IDX_W-1:0] idx, ppm_pkg::cfg_t val);
            if (idx <= ppm_pkg::IDX_W'(ppm_pkg::REG_BRAKE_FAULT_MS))
                regs[idx[2:0]] = val;
        endfunction

        // Offset and Q16 gain, truncated, clamped to the angle range
        function ppm_pkg::angle_t pedal_angle(ppm_pkg::adc_t raw, ppm_pkg::cfg_t zero,
                                              ppm_pkg::cfg_t gain);
            logic [31:0] prod;
            if (raw <= zero)
                return '0;
            prod = (32'(raw) - 32'(zero)) * 32'(gain);
            prod = prod >> 16;
            return (prod > 32'(ppm_pkg::ANGLE_MAX)) ? ppm_pkg::ANGLE_MAX
                                                    : ppm_pkg::angle_t'(prod);
        endfunction

        function void predict_sample(ppm_pkg::adc_t a_raw, ppm_pkg::adc_t b_raw,
                                     ppm_pkg::adc_t brake, logic [31:0] now);
            pedal_result_t   r;
            ppm_pkg::angle_t hi;
            ppm_pkg::angle_t diff;
            logic [31:0]     elapsed;
            logic            tfault;
            // brake band monitor, the fault holds once set
            if (brake < regs[ppm_pkg::REG_BRAKE_LOW_LIMIT] ||
                brake > regs[ppm_pkg::REG_BRAKE_HIGH_LIMIT]) begin
                elapsed = now - brake_ok_ms;
                if (elapsed >= 32'(regs[ppm_pkg::REG_BRAKE_FAULT_MS])) begin
                    brake_ok_ms = now;
                    brake_latch = 1'b1;
                end
            end else begin
                brake_ok_ms = now;
            end
            r.a_angle = pedal_angle(a_raw, regs[ppm_pkg::REG_PEDAL_A_ZERO],
                                    regs[ppm_pkg::REG_PEDAL_A_GAIN]);
            r.b_angle = pedal_angle(b_raw, regs[ppm_pkg::REG_PEDAL_B_ZERO],
                                    regs[ppm_pkg::REG_PEDAL_B_GAIN]);
            hi   = (r.a_angle > r.b_angle) ? r.a_angle : r.b_angle;
            diff = (r.a_angle > r.b_angle) ? r.a_angle - r.b_angle : r.b_angle - r.a_angle;
            // more than ten percent apart, in integer form
            r.disagreeing = (10 * int'(diff)) > int'(hi);
            tfault = 1'b0;
            if (r.disagreeing) begin
                if (!disagree_on) begin
                    disagree_on = 1'b1;
                    disagree_t0 = now;
                end
                elapsed = now - disagree_t0;
                tfault  = elapsed > 32'(regs[ppm_pkg::REG_DISAGREE_WINDOW_MS]);
            end else begin
                disagree_on = 1'b0;
            end
            r.torque_fault = tfault;
            r.drive        = tfault ? '0 : hi[ppm_pkg::ANGLE_W-1:4];
            r.brake_fault  = brake_latch;
            expected_results.push_back(r);
        endfunction

        function string show(pedal_result_t r);
            return $sformatf("a=%0d b=%0d drive=%0d tf=%0b dis=%0b bf=%0b", r.a_angle,
                             r.b_angle, r.drive, r.torque_fault, r.disagreeing, r.brake_fault);
        endfunction

        function void note_mismatch(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_result(pedal_result_t got);
            pedal_result_t want;
            if (expected_results.size() == 0) begin
                note_mismatch({"result with no request pending: ", show(got)});
                return;
            end
            want = expected_results.pop_front();
            if (got.a_angle !== want.a_angle || got.b_angle !== want.b_angle ||
                got.drive !== want.drive || got.torque_fault !== want.torque_fault ||
                got.disagreeing !== want.disagreeing || got.brake_fault !== want.brake_fault)
                note_mismatch({"expected ", show(want), " got ", show(got)});
        endfunction
    endclass

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [ppm_pkg::IDX_W-1:0]   cfg_index = '0;
    ppm_pkg::cfg_t               cfg_data  = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    ppm_pkg::adc_t               s_pedal_a_raw = '0;
    ppm_pkg::adc_t               s_pedal_b_raw = '0;
    ppm_pkg::adc_t               s_brake_raw   = '0;
    logic [31:0]                 s_now_ms      = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    ppm_pkg::angle_t             m_pedal_a_angle;
    ppm_pkg::angle_t             m_pedal_b_angle;
    logic [ppm_pkg::DRIVE_W-1:0] m_drive_value;
    logic                        m_torque_fault;
    logic                        m_disagreeing;
    logic                        m_brake_fault;

    monitor_scoreboard  sb;
    bit                 gaps_off = 1'b0;
    logic [31:0]        clock_ms = '0;
    int                 pair_left = 0;
    int                 pair_mode = 0;
    int                 brake_left = 0;
    int                 brake_mode = 0;
    int                 ready_hold = 0;
    bit                 ready_level = 1'b0;

    pedal_plausibility_monitor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pedal_a_raw   (s_pedal_a_raw),
        .s_pedal_b_raw   (s_pedal_b_raw),
        .s_brake_raw     (s_brake_raw),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pedal_a_angle (m_pedal_a_angle),
        .m_pedal_b_angle (m_pedal_b_angle),
        .m_drive_value   (m_drive_value),
        .m_torque_fault  (m_torque_fault),
        .m_disagreeing   (m_disagreeing),
        .m_brake_fault   (m_brake_fault)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check every accepted result, stall in stretches of random length
    always @(posedge aclk) begin
        int r;
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_pedal_a_angle, m_pedal_b_angle, m_drive_value,
                             m_torque_fault, m_disagreeing, m_brake_fault});
        if (ready_hold != 0) begin
            ready_hold--;
        end else begin
            r = $urandom_range(0, 99);
            ready_level = (r < 50);
            if (r < 50)
                ready_hold = $urandom_range(1, 40);
            else if (r < 90)
                ready_hold = $urandom_range(1, 3);
            else if (r < 98)
                ready_hold = $urandom_range(4, 15);
            else
                ready_hold = $urandom_range(20, 60);
        end
        m_ready <= ready_level;
    end

    // Sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gaps_off || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Register value, a quarter of the time over the whole range
    function automatic ppm_pkg::cfg_t pick_setting(int lo, int hi);
        if ($urandom_range(0, 3) == 0)
            return ppm_pkg::cfg_t'($urandom_range(0, 65535));
        return ppm_pkg::cfg_t'($urandom_range(lo, hi));
    endfunction

    // Valid stays up across back-to-back requests; caller lowers it when idle
    task automatic write_reg(logic [ppm_pkg::IDX_W-1:0] idx, ppm_pkg::cfg_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_settings(ppm_pkg::cfg_t a_zero, ppm_pkg::cfg_t a_gain,
                                 ppm_pkg::cfg_t b_zero, ppm_pkg::cfg_t b_gain,
                                 ppm_pkg::cfg_t window, ppm_pkg::cfg_t low,
                                 ppm_pkg::cfg_t high, ppm_pkg::cfg_t fault_ms);
        write_reg(ppm_pkg::REG_PEDAL_A_ZERO, a_zero);
        write_reg(ppm_pkg::REG_PEDAL_A_GAIN, a_gain);
        write_reg(ppm_pkg::REG_PEDAL_B_ZERO, b_zero);
        write_reg(ppm_pkg::REG_PEDAL_B_GAIN, b_gain);
        write_reg(ppm_pkg::REG_DISAGREE_WINDOW_MS, window);
        write_reg(ppm_pkg::REG_BRAKE_LOW_LIMIT, low);
        write_reg(ppm_pkg::REG_BRAKE_HIGH_LIMIT, high);
        write_reg(ppm_pkg::REG_BRAKE_FAULT_MS, fault_ms);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(ppm_pkg::adc_t a_raw, ppm_pkg::adc_t b_raw,
                               ppm_pkg::adc_t brake, logic [31:0] now);
        int gap;
        s_valid       <= 1'b1;
        s_pedal_a_raw <= a_raw;
        s_pedal_b_raw <= b_raw;
        s_brake_raw   <= brake;
        s_now_ms      <= now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.predict_sample(a_raw, b_raw, brake, now);
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold requests until every result is back, then let the pipeline settle
    task automatic drain();
        int w;
        s_valid <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && sb.expected_results.size() != 0; w++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Boundaries under the reset settings; the brake fault latches only at the end
    task automatic run_directed();
        send_sample(16'd0, 16'd0, 16'd0, 32'd0);
        send_sample(16'd8440, 16'd7944, 16'd4500, 32'd10);
        send_sample(16'd8441, 16'd7945, 16'd48000, 32'd20);
        send_sample(16'hFFFF, 16'hFFFF, 16'd48001, 32'd30);
        send_sample(16'hFFFF, 16'hFFFF, 16'd4499, 32'd40);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd50);
        // disagreement held exactly the window, then one past it
        send_sample(16'hFFFF, 16'd7944, 16'd20000, 32'd1000);
        send_sample(16'hFFFF, 16'd7944, 16'd20000, 32'd1100);
        send_sample(16'hFFFF, 16'd7944, 16'd20000, 32'd1101);
        send_sample(16'd8440, 16'hFFFF, 16'd20000, 32'd1200);
        send_sample(16'd30000, 16'd30000, 16'd20000, 32'd1210);
        // disagreement across the timestamp wrap
        send_sample(16'd30000, 16'd30000, 16'd20000, 32'hFFFF_FFA0);
        send_sample(16'hFFFF, 16'd0, 16'd20000, 32'hFFFF_FFC0);
        send_sample(16'hFFFF, 16'd0, 16'd20000, 32'h0000_0025);
        send_sample(16'hFFFF, 16'd0, 16'd20000, 32'hFFFF_FFFF);
        // brake out of band one short of the fault time, then exactly at it
        send_sample(16'd30000, 16'd30000, 16'd20000, 32'd5000);
        send_sample(16'd30000, 16'd30000, 16'd0, 32'd5099);
        send_sample(16'd30000, 16'd30000, 16'd0, 32'd5100);
        send_sample(16'd30000, 16'd30000, 16'd20000, 32'd5200);
    endtask

    // Episodes of agreeing or disagreeing sensors and in- or out-of-band brake
    task automatic run_random(int count);
        int              i;
        int              r;
        int              low;
        int              high;
        longint          b_l;
        longint          gb;
        ppm_pkg::adc_t   a_raw;
        ppm_pkg::adc_t   b_raw;
        ppm_pkg::adc_t   brake;
        ppm_pkg::angle_t target;
        for (i = 0; i < count; i++) begin
            if (pair_left == 0) begin
                pair_mode = $urandom_range(0, 9);
                pair_left = $urandom_range(1, 25);
            end
            pair_left--;
            if (brake_left == 0) begin
                brake_mode = $urandom_range(0, 9);
                brake_left = $urandom_range(1, 20);
            end
            brake_left--;
            // pedal pair
            if ($urandom_range(0, 9) == 0)
                a_raw = ppm_pkg::adc_t'($urandom_range(0, sb.regs[ppm_pkg::REG_PEDAL_A_ZERO]));
            else
                a_raw = ppm_pkg::adc_t'($urandom_range(0, 65535));
            b_raw = ppm_pkg::adc_t'($urandom_range(0, 65535));
            gb    = sb.regs[ppm_pkg::REG_PEDAL_B_GAIN];
            if (pair_mode <= 5 && gb != 0) begin
                target = sb.pedal_angle(a_raw, sb.regs[ppm_pkg::REG_PEDAL_A_ZERO],
                                        sb.regs[ppm_pkg::REG_PEDAL_A_GAIN]);
                b_l = longint'(sb.regs[ppm_pkg::REG_PEDAL_B_ZERO]) +
                      ((longint'(target) << 16) + gb - 1) / gb +
                      longint'($urandom_range(0, 8)) - 4;
                if (b_l < 0)
                    b_l = 0;
                if (b_l > 65535)
                    b_l = 65535;
                b_raw = ppm_pkg::adc_t'(b_l);
            end else if (pair_mode <= 7 && $urandom_range(0, 2) == 0) begin
                b_raw = ppm_pkg::adc_t'($urandom_range(0, sb.regs[ppm_pkg::REG_PEDAL_B_ZERO]));
            end
            // brake reading
            low  = sb.regs[ppm_pkg::REG_BRAKE_LOW_LIMIT];
            high = sb.regs[ppm_pkg::REG_BRAKE_HIGH_LIMIT];
            if (brake_mode <= 6 && low <= high)
                brake = ppm_pkg::adc_t'($urandom_range(low, high));
            else if (brake_mode == 7 && low > 0)
                brake = ppm_pkg::adc_t'($urandom_range(0, low - 1));
            else if (brake_mode == 8 && high < 65535)
                brake = ppm_pkg::adc_t'($urandom_range(high + 1, 65535));
            else
                brake = ppm_pkg::adc_t'($urandom_range(0, 65535));
            // timestamp: small steps, some longer, rare jumps and wraps
            r = $urandom_range(0, 99);
            if (r < 70)
                clock_ms += $urandom_range(0, 30);
            else if (r < 90)
                clock_ms += $urandom_range(0, 200);
            else if (r < 96)
                clock_ms += $urandom_range(200, 2000);
            else if (r < 98)
                clock_ms += $urandom_range(60000, 70000);
            else if (r < 99)
                clock_ms = $urandom;
            else
                clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
            send_sample(a_raw, b_raw, brake, clock_ms);
        end
    endtask

    // Limit on the whole run
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int ph;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random(PHASE_ITEMS);

        // extreme settings: full gain, zero window and fault time, widest band
        drain();
        load_settings('0, '1, '0, '1, '0, '0, '1, '0);
        write_reg(IDX_PAST_END, ppm_pkg::cfg_t'($urandom_range(0, 65535)));
        write_reg(IDX_TOP, ppm_pkg::cfg_t'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
        run_random(PHASE_ITEMS);

        // other extremes: sensor A pinned to zero, no B gain, inverted brake band
        drain();
        load_settings('1, pick_setting(1, 65535), pick_setting(0, 16000), '0,
                      '1, '1, '0, '1);
        run_random(PHASE_ITEMS);

        // random settings, one phase with no sender gaps
        for (ph = 0; ph < 5; ph++) begin
            drain();
            gaps_off = (ph == 1);
            load_settings(pick_setting(0, 16000), pick_setting(500, 20000),
                          pick_setting(0, 16000), pick_setting(500, 20000),
                          pick_setting(0, 250), pick_setting(0, 10000),
                          pick_setting(30000, 65535), pick_setting(0, 250));
            run_random(PHASE_ITEMS);
        end

        drain();
        if (sb.expected_results.size() != 0)
            sb.note_mismatch($sformatf("%0d results never arrived",
                                       sb.expected_results.size()));
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ppm_pkg.sv
hw/rtl/ppm_angle_map.sv
hw/rtl/pedal_plausibility_monitor.sv
sim/pedal_plausibility_monitor_tb.sv
